[rtl/core/lfcp_pkg.sv]
// Shared constants, codes and controller/datapath types for the line fit block.
`timescale 1ns / 1ps
`default_nettype none
package lfcp_pkg;

  localparam int MAX_POINTS = 256;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int COORD_W    = 32;
  localparam int SUM_W      = COORD_W + ADDR_W;
  localparam int ITER_W     = 9;

  localparam logic [ITER_W-1:0] ITER_RESET = 9'd16;
  localparam logic [ITER_W-1:0] ITER_CAP   = 9'd256;

  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
  localparam logic [32:0]        EPS_Q30 = 33'd10737;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_DOT,
    MUL_TERM,
    MUL_SQ
  } mul_sel_t;

  typedef enum logic {
    DIV_CENTROID,
    DIV_NORM
  } div_kind_t;

  typedef struct packed {
    logic              load;
    logic              clear;
    logic              div_start;
    div_kind_t         div_kind;
    logic              div_take;
    logic [1:0]        axis;
    logic              acc_init;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              q_load;
    mul_sel_t          mul;
    logic [1:0]        mul_axis;
    logic              dot_add;
    logic              acc_add;
    logic [1:0]        add_axis;
    logic              n2_add;
    logic              norm_init;
    logic              norm_shift;
    logic              sqrt_start;
    logic              nd_unit;
    logic              dir_commit;
    logic              pass_inc;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [ITER_W-1:0] passes;
    logic [ITER_W-1:0] iters;
    logic              div_done;
    logic              sqrt_done;
    logic              m_zero;
    logic              norm_ok;
    logic              close;
  } status_t;

endpackage
`default_nettype wire

[rtl/core/lfcp_if.sv]
// Point and result stream interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface lfcp_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic               final_point;

  modport source (output valid, point_x, point_y, point_z, final_point, input ready);
  modport sink   (input valid, point_x, point_y, point_z, final_point, output ready);
endinterface

interface lfcp_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  logic [8:0]         passes_used;
  logic               overflowed;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  passes_used, overflowed, input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  passes_used, overflowed, output ready);
endinterface
`default_nettype wire

[rtl/core/lfcp_div.sv]
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 33-bit divisor.
`timescale 1ns / 1ps
`default_nettype none
module lfcp_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [32:0] divisor,
  output logic [63:0]      quot,
  output logic             done
);

  logic [63:0] dvd;
  logic [33:0] rem;
  logic [32:0] dsr;
  logic [6:0]  cnt;
  logic        busy;
  logic [33:0] trial;
  logic        ge;

  assign trial = {rem[32:0], dvd[63]};
  assign ge    = trial >= {1'b0, dsr};
  assign quot  = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= ge ? trial - {1'b0, dsr} : trial;
        dvd <= {dvd[62:0], ge};
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/lfcp_isqrt.sv]
// Digit-by-digit integer square root of a 64-bit value, one step per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lfcp_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic [32:0]      root,
  output logic             done
);

  logic [63:0] n;
  logic [63:0] res;
  logic [63:0] bit_q;
  logic [4:0]  cnt;
  logic        busy;
  logic [63:0] trial;

  assign trial = res + bit_q;
  assign root  = res[32:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        n     <= radicand;
        res   <= '0;
        bit_q <= 64'h4000_0000_0000_0000;
      end else if (busy) begin
        if (n >= trial) begin
          n   <= n - trial;
          res <= (res >> 1) + bit_q;
        end else begin
          res <= res >> 1;
        end
        bit_q <= bit_q >> 2;
        cnt   <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/lfcp_datapath.sv]
// Datapath: point store, sums, centroid, power iteration accumulators, normalizer.
`timescale 1ns / 1ps
`default_nettype none
module lfcp_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lfcp_pkg::cmd_t     cmd,
  output lfcp_pkg::status_t       status,
  input  wire logic               cfg_we,
  input  wire logic [8:0]         cfg_wdata,
  input  wire logic signed [31:0] in_x,
  input  wire logic signed [31:0] in_y,
  input  wire logic signed [31:0] in_z,
  output logic signed [31:0]      origin_x,
  output logic signed [31:0]      origin_y,
  output logic signed [31:0]      origin_z,
  output logic signed [31:0]      dir_x,
  output logic signed [31:0]      dir_y,
  output logic signed [31:0]      dir_z,
  output logic [8:0]              passes_used,
  output logic                    overflowed
);

  localparam logic signed [64:0] SAT_HI = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SAT_LO = -65'sh0_7FFF_FFFF_FFFF_FFFF;

  logic [95:0] mem [lfcp_pkg::MAX_POINTS];
  logic [95:0] rdata;

  logic [lfcp_pkg::CNT_W-1:0]         count;
  logic signed [lfcp_pkg::SUM_W-1:0]  sums [3];
  logic                               drop;
  logic [lfcp_pkg::ITER_W-1:0]        max_iter;
  logic [lfcp_pkg::ITER_W-1:0]        passes;
  logic signed [32:0]                 c [3];
  logic signed [31:0]                 last [3];
  logic signed [31:0]                 nd [3];
  logic signed [32:0]                 qv [3];
  logic signed [35:0]                 dot;
  logic signed [69:0]                 prod;
  logic signed [63:0]                 acc [3];
  logic signed [63:0]                 w [3];
  logic [63:0]                        m;
  logic [63:0]                        n2;

  logic signed [33:0] mul_a;
  logic signed [35:0] mul_b;
  logic [31:0]        wmag [3];
  logic [63:0]        amag [3];
  logic [63:0]        mmax;
  logic [lfcp_pkg::SUM_W-1:0] smag;
  logic signed [64:0] acc_sum;
  logic signed [64:0] term;
  logic               room;
  logic [63:0]        dvd;
  logic [32:0]        dsr;
  logic [63:0]        quot;
  logic               div_done;
  logic [32:0]        root;
  logic               sqrt_done;
  logic               close;
  logic signed [32:0] diff [3];
  logic [32:0]        dabs [3];

  assign room = count < lfcp_pkg::CNT_W'(lfcp_pkg::MAX_POINTS);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      wmag[j] = w[j][63] ? 32'(-w[j]) : w[j][31:0];
      amag[j] = acc[j][63] ? 64'(-acc[j]) : 64'(acc[j]);
      diff[j] = 33'(nd[j]) - 33'(last[j]);
      dabs[j] = diff[j][32] ? 33'(-diff[j]) : 33'(diff[j]);
    end
    mmax = amag[0];
    if (amag[1] > mmax) mmax = amag[1];
    if (amag[2] > mmax) mmax = amag[2];
    close = (dabs[0] < lfcp_pkg::EPS_Q30) && (dabs[1] < lfcp_pkg::EPS_Q30) &&
            (dabs[2] < lfcp_pkg::EPS_Q30);
    smag = sums[cmd.axis][lfcp_pkg::SUM_W-1] ? lfcp_pkg::SUM_W'(-sums[cmd.axis])
                                             : lfcp_pkg::SUM_W'(sums[cmd.axis]);
    if (cmd.div_kind == lfcp_pkg::DIV_CENTROID) begin
      dvd = 64'(smag) + 64'(count >> 1);
      dsr = 33'(count);
    end else begin
      dvd = {2'b00, wmag[cmd.axis], 30'b0} + 64'(root >> 1);
      dsr = root;
    end
    unique case (cmd.mul)
      lfcp_pkg::MUL_DOT: begin
        mul_a = 34'(qv[cmd.mul_axis]);
        mul_b = 36'(last[cmd.mul_axis]);
      end
      lfcp_pkg::MUL_TERM: begin
        mul_a = 34'(qv[cmd.mul_axis]);
        mul_b = dot;
      end
      lfcp_pkg::MUL_SQ: begin
        mul_a = {2'b00, wmag[cmd.mul_axis]};
        mul_b = {4'b0000, wmag[cmd.mul_axis]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    term    = 65'($signed(prod[69:8]));
    acc_sum = 65'(acc[cmd.add_axis]) + term;
  end

  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      mem[count[lfcp_pkg::ADDR_W-1:0]] <= {in_z, in_y, in_x};
    end
    if (cmd.rd_en) begin
      rdata <= mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count   <= '0;
      drop    <= 1'b0;
      passes  <= '0;
      for (int j = 0; j < 3; j++) begin
        sums[j] <= '0;
        c[j]    <= '0;
      end
      last[0] <= '0;
      last[1] <= lfcp_pkg::ONE_Q30;
      last[2] <= '0;
    end else begin
      if (cmd.load) begin
        if (room) begin
          count   <= count + 1'b1;
          sums[0] <= sums[0] + lfcp_pkg::SUM_W'(in_x);
          sums[1] <= sums[1] + lfcp_pkg::SUM_W'(in_y);
          sums[2] <= sums[2] + lfcp_pkg::SUM_W'(in_z);
        end else begin
          drop <= 1'b1;
        end
      end
      if (cmd.div_take && cmd.div_kind == lfcp_pkg::DIV_CENTROID) begin
        c[cmd.axis] <= sums[cmd.axis][lfcp_pkg::SUM_W-1] ? -$signed(quot[32:0])
                                                          : $signed(quot[32:0]);
      end
      if (cmd.pass_inc) passes <= passes + 1'b1;
      if (cmd.dir_commit) begin
        for (int j = 0; j < 3; j++) last[j] <= nd[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter <= lfcp_pkg::ITER_RESET;
    end else if (cfg_we) begin
      max_iter <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.q_load) begin
      qv[0] <= 33'(signed'(rdata[31:0]))  - c[0];
      qv[1] <= 33'(signed'(rdata[63:32])) - c[1];
      qv[2] <= 33'(signed'(rdata[95:64])) - c[2];
      dot   <= '0;
    end else if (cmd.dot_add) begin
      dot <= dot + prod[65:30];
    end
    if (cmd.acc_init) begin
      for (int j = 0; j < 3; j++) acc[j] <= $signed({{32{last[j][31]}}, last[j]}) >>> 6;
    end else if (cmd.acc_add) begin
      priority if (acc_sum > SAT_HI) acc[cmd.add_axis] <= SAT_HI[63:0];
      else if (acc_sum < SAT_LO) acc[cmd.add_axis] <= SAT_LO[63:0];
      else acc[cmd.add_axis] <= acc_sum[63:0];
    end
    if (cmd.norm_init) begin
      for (int j = 0; j < 3; j++) w[j] <= acc[j];
      m  <= mmax;
      n2 <= '0;
    end else begin
      if (cmd.norm_shift) begin
        // floor shifts compose, so one bit a step matches one long shift
        if (m[63:31] != '0) begin
          for (int j = 0; j < 3; j++) w[j] <= w[j] >>> 1;
          m <= m >> 1;
        end else begin
          for (int j = 0; j < 3; j++) w[j] <= w[j] <<< 1;
          m <= m << 1;
        end
      end
      if (cmd.n2_add) n2 <= n2 + prod[63:0];
    end
    if (cmd.nd_unit) begin
      nd[0] <= '0;
      nd[1] <= lfcp_pkg::ONE_Q30;
      nd[2] <= '0;
    end else if (cmd.div_take && cmd.div_kind == lfcp_pkg::DIV_NORM) begin
      nd[cmd.axis] <= w[cmd.axis][63] ? -$signed(quot[31:0]) : $signed(quot[31:0]);
    end
    if (cmd.out_load) begin
      origin_x    <= c[0][31:0];
      origin_y    <= c[1][31:0];
      origin_z    <= c[2][31:0];
      dir_x       <= last[0];
      dir_y       <= last[1];
      dir_z       <= last[2];
      passes_used <= passes;
      overflowed  <= drop;
    end
  end

  lfcp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dsr),
    .quot     (quot),
    .done     (div_done)
  );

  lfcp_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (n2),
    .root     (root),
    .done     (sqrt_done)
  );

  always_comb begin
    status.count     = count;
    status.passes    = passes;
    status.iters     = (max_iter > lfcp_pkg::ITER_CAP) ? lfcp_pkg::ITER_CAP : max_iter;
    status.div_done  = div_done;
    status.sqrt_done = sqrt_done;
    status.m_zero    = (m == '0);
    status.norm_ok   = (m[63:31] == '0) && m[30];
    status.close     = close;
  end

endmodule
`default_nettype wire

[rtl/core/lfcp_ctrl.sv]
// Controller: load handshake, fit sequencing and result handshake.
`timescale 1ns / 1ps
`default_nettype none
module lfcp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_final,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire lfcp_pkg::status_t status,
  output lfcp_pkg::cmd_t         cmd
);

  typedef enum logic [4:0] {
    S_LOAD, S_CSTART, S_CDIV, S_CWAIT, S_PASS,
    S_PT_RD, S_PT_Q, S_PT_D0, S_PT_D1, S_PT_D2, S_PT_DS,
    S_PT_T0, S_PT_T1, S_PT_T2, S_PT_TS,
    S_NINIT, S_NCHK, S_SQ0, S_SQ1, S_SQ2, S_SQ3,
    S_SROOT, S_SWAIT, S_NDIV, S_NWAIT, S_CMP, S_DONE
  } state_t;

  state_t                      state;
  logic [1:0]                  axis;
  logic [lfcp_pkg::ADDR_W-1:0] p;
  logic                        last_pt;
  logic                        out_free;

  assign in_ready = (state == S_LOAD);
  assign last_pt  = {1'b0, p} == status.count - 1'b1;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd          = '0;
    cmd.axis     = axis;
    cmd.rd_addr  = p;
    cmd.div_kind = lfcp_pkg::DIV_CENTROID;
    cmd.mul      = lfcp_pkg::MUL_NONE;
    unique case (state)
      S_LOAD:   cmd.load = in_valid;
      S_CDIV:   cmd.div_start = 1'b1;
      S_CWAIT:  cmd.div_take = status.div_done;
      S_PASS: begin
        cmd.pass_inc = (status.passes != status.iters);
        cmd.acc_init = (status.passes != status.iters);
      end
      S_PT_RD:  cmd.rd_en = 1'b1;
      S_PT_Q:   cmd.q_load = 1'b1;
      S_PT_D0: begin
        cmd.mul = lfcp_pkg::MUL_DOT; cmd.mul_axis = 2'd0;
      end
      S_PT_D1: begin
        cmd.mul = lfcp_pkg::MUL_DOT; cmd.mul_axis = 2'd1; cmd.dot_add = 1'b1;
      end
      S_PT_D2: begin
        cmd.mul = lfcp_pkg::MUL_DOT; cmd.mul_axis = 2'd2; cmd.dot_add = 1'b1;
      end
      S_PT_DS:  cmd.dot_add = 1'b1;
      S_PT_T0: begin
        cmd.mul = lfcp_pkg::MUL_TERM; cmd.mul_axis = 2'd0;
      end
      S_PT_T1: begin
        cmd.mul = lfcp_pkg::MUL_TERM; cmd.mul_axis = 2'd1;
        cmd.acc_add = 1'b1; cmd.add_axis = 2'd0;
      end
      S_PT_T2: begin
        cmd.mul = lfcp_pkg::MUL_TERM; cmd.mul_axis = 2'd2;
        cmd.acc_add = 1'b1; cmd.add_axis = 2'd1;
      end
      S_PT_TS: begin
        cmd.acc_add = 1'b1; cmd.add_axis = 2'd2;
      end
      S_NINIT:  cmd.norm_init = 1'b1;
      S_NCHK: begin
        cmd.nd_unit    = status.m_zero;
        cmd.norm_shift = !status.m_zero && !status.norm_ok;
      end
      S_SQ0: begin
        cmd.mul = lfcp_pkg::MUL_SQ; cmd.mul_axis = 2'd0;
      end
      S_SQ1: begin
        cmd.mul = lfcp_pkg::MUL_SQ; cmd.mul_axis = 2'd1; cmd.n2_add = 1'b1;
      end
      S_SQ2: begin
        cmd.mul = lfcp_pkg::MUL_SQ; cmd.mul_axis = 2'd2; cmd.n2_add = 1'b1;
      end
      S_SQ3:    cmd.n2_add = 1'b1;
      S_SROOT:  cmd.sqrt_start = 1'b1;
      S_NDIV: begin
        cmd.div_kind  = lfcp_pkg::DIV_NORM;
        cmd.div_start = 1'b1;
      end
      S_NWAIT: begin
        cmd.div_kind = lfcp_pkg::DIV_NORM;
        cmd.div_take = status.div_done;
      end
      S_CMP:    cmd.dir_commit = !status.close;
      S_DONE: begin
        cmd.out_load = out_free;
        cmd.clear    = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      axis      <= '0;
      p         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_LOAD:   if (in_valid && in_final) state <= S_CSTART;
        S_CSTART: begin
          axis <= '0;
          state <= (status.count == '0) ? S_DONE : S_CDIV;
        end
        S_CDIV:   state <= S_CWAIT;
        S_CWAIT: begin
          if (status.div_done) begin
            if (axis == 2'd2) begin
              state <= S_PASS;
            end else begin
              axis  <= axis + 2'd1;
              state <= S_CDIV;
            end
          end
        end
        S_PASS: begin
          p <= '0;
          state <= (status.passes == status.iters) ? S_DONE : S_PT_RD;
        end
        S_PT_RD:  state <= S_PT_Q;
        S_PT_Q:   state <= S_PT_D0;
        S_PT_D0:  state <= S_PT_D1;
        S_PT_D1:  state <= S_PT_D2;
        S_PT_D2:  state <= S_PT_DS;
        S_PT_DS:  state <= S_PT_T0;
        S_PT_T0:  state <= S_PT_T1;
        S_PT_T1:  state <= S_PT_T2;
        S_PT_T2:  state <= S_PT_TS;
        S_PT_TS: begin
          if (last_pt) begin
            state <= S_NINIT;
          end else begin
            p     <= p + 1'b1;
            state <= S_PT_RD;
          end
        end
        S_NINIT:  state <= S_NCHK;
        S_NCHK: begin
          priority if (status.m_zero) state <= S_CMP;
          else if (status.norm_ok) state <= S_SQ0;
          else state <= S_NCHK;
        end
        S_SQ0:    state <= S_SQ1;
        S_SQ1:    state <= S_SQ2;
        S_SQ2:    state <= S_SQ3;
        S_SQ3:    state <= S_SROOT;
        S_SROOT:  state <= S_SWAIT;
        S_SWAIT: begin
          if (status.sqrt_done) begin
            axis  <= '0;
            state <= S_NDIV;
          end
        end
        S_NDIV:   state <= S_NWAIT;
        S_NWAIT: begin
          if (status.div_done) begin
            if (axis == 2'd2) begin
              state <= S_CMP;
            end else begin
              axis  <= axis + 2'd1;
              state <= S_NDIV;
            end
          end
        end
        S_CMP:    state <= status.close ? S_DONE : S_PASS;
        S_DONE:   if (out_free) state <= S_LOAD;
        default:  state <= S_LOAD;
      endcase
    end
  end

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten while held");

  a_final_stops_load: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_final) |=> !in_ready)
    else $error("load continued after final item");

  a_pass_limit: assert property (@(posedge clk) disable iff (rst)
    status.passes <= status.iters)
    else $error("pass count beyond limit");

  a_point_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_PT_RD) |-> ({1'b0, p} < status.count))
    else $error("point index beyond stored count");

endmodule
`default_nettype wire

[rtl/core/line_fit_centroid_power_iteration.sv]
// Top level of the streamed 3D least-squares line fit.
// Points stream in one item per cycle and go into a 256-entry store with running sums;
// a point past capacity is dropped and sets overflowed. The item marked final_point
// (itself a point) starts the fit and the input stalls until its result is handed to
// the output register. The fit takes three centroid divisions, then for each power
// iteration pass a per-point sequence (one shared multiplier, six products per point),
// one-bit normalizing shifts and checks and, unless the vector is zero, squares, a
// square root and three divisions. The store needs no clearing pass after reset.
// max_iterations is written through cfg_we/cfg_wdata while the block is idle; the user
// must keep to this, the block does not enforce it; values above 256 act as 256.
`timescale 1ns / 1ps
`default_nettype none
module line_fit_centroid_power_iteration (
  input  wire logic       clk,
  input  wire logic       rst,
  lfcp_point_if.sink      points,
  lfcp_result_if.source   results,
  input  wire logic       cfg_we,
  input  wire logic [8:0] cfg_wdata
);

  lfcp_pkg::cmd_t    cmd;
  lfcp_pkg::status_t status;

  lfcp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (points.valid),
    .in_final  (points.final_point),
    .in_ready  (points.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lfcp_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_x        (points.point_x),
    .in_y        (points.point_y),
    .in_z        (points.point_z),
    .origin_x    (results.origin_x),
    .origin_y    (results.origin_y),
    .origin_z    (results.origin_z),
    .dir_x       (results.dir_x),
    .dir_y       (results.dir_y),
    .dir_z       (results.dir_z),
    .passes_used (results.passes_used),
    .overflowed  (results.overflowed)
  );

endmodule
`default_nettype wire
